[design/assert_macros.svh]
// Assertion helpers included by the blend module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/gcab_pkg.sv]
`default_nettype none

package gcab_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_FORMAT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COVERAGE_BITS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOREGROUND     = 2'd2;

    localparam logic FORMAT_RGB565 = 1'b0;
    localparam logic FORMAT_BGR888 = 1'b1;

    // Reciprocals for widening 5-bit and 6-bit channels: ceil(2^18/31), ceil(2^20/63).
    localparam logic [13:0] EXP5_RECIP = 14'd8457;
    localparam logic [14:0] EXP6_RECIP = 15'd16645;

    // Stage enables handed to a colour lane.
    typedef struct packed {
        logic en_mix;
        logic en_div;
    } gcab_lane_ctrl_t;

    // ceil(2^24 / (2^bits - 1)); exact quotient for every numerator the block forms.
    function automatic logic [24:0] coverage_recip(input logic [3:0] bits);
        logic [24:0] r;
        case (bits)
            4'd1: r = 25'd16777216;
            4'd2: r = 25'd5592406;
            4'd3: r = 25'd2396746;
            4'd4: r = 25'd1118482;
            4'd5: r = 25'd541201;
            4'd6: r = 25'd266306;
            4'd7: r = 25'd132105;
            4'd8: r = 25'd65794;
            default: r = 25'd0;
        endcase
        return r;
    endfunction

    // Quotient by 255, exact for any 16-bit numerator below 65536 - 256.
    function automatic logic [7:0] div255(input logic [15:0] y);
        logic [16:0] t;
        t = {1'b0, y} + {9'd0, y[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

[design/glyph_coverage_alpha_blend.sv]
// Six register stages, each with its own valid bit, carry a pixel from its input
// transfer to the result that the last stage offers on the m_ channel.
// Throughput: one pixel per clock, unless an output stall has filled the pipeline.
// A stage only stalls when it and every stage after it hold an item.
// Reset (aresetn low, synchronous) empties the pipeline and restores the
// registers: RGB565 format, eight-bit coverage, black foreground.
`default_nettype none
`include "assert_macros.svh"

module glyph_coverage_alpha_blend (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration write port.
    input  wire logic                           cfg_write_enable,
    input  wire logic [gcab_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [gcab_pkg::CFG_DATA_W-1:0]  cfg_write_data,
    // Glyph pixel input channel.
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [15:0]                    s_coverage_window,
    input  wire logic [2:0]                     s_bit_position,
    input  wire logic [23:0]                    s_background_pixel,
    // Blended pixel output channel.
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_write_enable,
    output logic [23:0]                         m_new_pixel,
    output logic [7:0]                          m_opacity
);
    import gcab_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are only expected while the block is
    // idle, so every stage reads them directly.
    // ------------------------------------------------------------------
    logic        pixel_format_reg;
    logic [3:0]  coverage_bits_reg;
    logic [23:0] foreground_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_format_reg  <= FORMAT_RGB565;
            coverage_bits_reg <= 4'd8;
            foreground_reg    <= 24'd0;
        end else if (cfg_write_enable) begin
            case (cfg_index)
                CFG_PIXEL_FORMAT:  pixel_format_reg  <= cfg_write_data[0];
                CFG_COVERAGE_BITS: coverage_bits_reg <= cfg_write_data[3:0];
                CFG_FOREGROUND:    foreground_reg    <= cfg_write_data[23:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. A stage takes a new item when it is empty or when
    // the stage after it moves on as well; the last stage moves on when its
    // result is taken. This lets bubbles close up during an output stall.
    // ------------------------------------------------------------------
    logic [5:0] stage_valid_reg;
    logic [5:0] stage_en;

    always_comb begin
        stage_en[5] = !stage_valid_reg[5] || m_ready;
        for (int i = 4; i >= 0; i--) begin
            stage_en[i] = !stage_valid_reg[i] || stage_en[i + 1];
        end
    end

    assign s_ready = stage_en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 6'd0;
        end else begin
            if (stage_en[0]) begin
                stage_valid_reg[0] <= s_valid;
            end
            for (int i = 1; i < 6; i++) begin
                if (stage_en[i]) begin
                    stage_valid_reg[i] <= stage_valid_reg[i - 1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: pick the coverage sample out of the window and form the
    // rounded numerator v*255 + m/2. The background is reduced to its
    // format and the RGB565 channels get their widening numerators.
    // ------------------------------------------------------------------
    logic        bits_ok;
    logic [4:0]  sample_shift;
    logic [15:0] window_shifted;
    logic [8:0]  mask_wide;
    logic [7:0]  sample_mask;
    logic [7:0]  sample_value;
    logic [15:0] x0_next;
    logic [12:0] yr0_next;
    logic [13:0] yg0_next;
    logic [12:0] yb0_next;
    logic [23:0] bgc0_next;

    logic [15:0] x0_reg;
    logic [12:0] yr0_reg;
    logic [13:0] yg0_reg;
    logic [12:0] yb0_reg;
    logic [23:0] bgc0_reg;

    always_comb begin
        bits_ok        = (coverage_bits_reg != 4'd0) && (coverage_bits_reg <= 4'd8);
        sample_shift   = 5'd16 - {2'b00, s_bit_position} - {1'b0, coverage_bits_reg};
        window_shifted = s_coverage_window >> sample_shift;
        mask_wide      = (9'd1 << coverage_bits_reg) - 9'd1;
        sample_mask    = mask_wide[7:0];
        sample_value   = window_shifted[7:0] & sample_mask;
        if (bits_ok) begin
            x0_next = {sample_value, 8'd0} - {8'd0, sample_value}
                    + {9'd0, sample_mask[7:1]};
        end else begin
            // An unsupported sample width always gives zero opacity.
            x0_next = 16'd0;
        end

        yr0_next = {s_background_pixel[15:11], 8'd0} - {8'd0, s_background_pixel[15:11]}
                 + 13'd15;
        yg0_next = {s_background_pixel[10:5], 8'd0} - {8'd0, s_background_pixel[10:5]}
                 + 14'd31;
        yb0_next = {s_background_pixel[4:0], 8'd0} - {8'd0, s_background_pixel[4:0]}
                 + 13'd15;

        if (pixel_format_reg == FORMAT_BGR888) begin
            bgc0_next = s_background_pixel;
        end else begin
            bgc0_next = {8'd0, s_background_pixel[15:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            x0_reg   <= x0_next;
            yr0_reg  <= yr0_next;
            yg0_reg  <= yg0_next;
            yb0_reg  <= yb0_next;
            bgc0_reg <= bgc0_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: reciprocal multiplications. Each numerator is small enough
    // that the truncated product is the exact quotient, so no correction
    // step follows.
    // ------------------------------------------------------------------
    logic [40:0] prod1_next;
    logic [26:0] pr1_next;
    logic [28:0] pg1_next;
    logic [26:0] pb1_next;

    logic [40:0] prod1_reg;
    logic [26:0] pr1_reg;
    logic [28:0] pg1_reg;
    logic [26:0] pb1_reg;
    logic [23:0] bgc1_reg;

    always_comb begin
        prod1_next = {25'd0, x0_reg} * {16'd0, coverage_recip(coverage_bits_reg)};
        pr1_next   = {14'd0, yr0_reg} * {13'd0, EXP5_RECIP};
        pg1_next   = {15'd0, yg0_reg} * {14'd0, EXP6_RECIP};
        pb1_next   = {14'd0, yb0_reg} * {13'd0, EXP5_RECIP};
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            prod1_reg <= prod1_next;
            pr1_reg   <= pr1_next;
            pg1_reg   <= pg1_next;
            pb1_reg   <= pb1_next;
            bgc1_reg  <= bgc0_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: take the quotients and select the 8-bit background channels
    // for the destination format.
    // ------------------------------------------------------------------
    logic [7:0] br2_next;
    logic [7:0] bgn2_next;
    logic [7:0] bb2_next;

    logic [7:0]  alpha2_reg;
    logic [7:0]  br2_reg;
    logic [7:0]  bgn2_reg;
    logic [7:0]  bb2_reg;
    logic [23:0] bgc2_reg;

    always_comb begin
        if (pixel_format_reg == FORMAT_BGR888) begin
            br2_next  = bgc1_reg[23:16];
            bgn2_next = bgc1_reg[15:8];
            bb2_next  = bgc1_reg[7:0];
        end else begin
            br2_next  = pr1_reg[25:18];
            bgn2_next = pg1_reg[27:20];
            bb2_next  = pb1_reg[25:18];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            alpha2_reg <= prod1_reg[31:24];
            br2_reg    <= br2_next;
            bgn2_reg   <= bgn2_next;
            bb2_reg    <= bb2_next;
            bgc2_reg   <= bgc1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stages 3 and 4: one lane per colour channel forms the weighted sum
    // and divides it by 255. Opacity and the raw background ride alongside.
    // ------------------------------------------------------------------
    gcab_lane_ctrl_t lane_ctrl;
    logic [7:0]      mix_r;
    logic [7:0]      mix_g;
    logic [7:0]      mix_b;

    logic [7:0]  alpha3_reg;
    logic [23:0] bgc3_reg;
    logic [7:0]  alpha4_reg;
    logic [23:0] bgc4_reg;

    assign lane_ctrl.en_mix = stage_en[3];
    assign lane_ctrl.en_div = stage_en[4];

    gcab_mix_lane u_lane_r (
        .aclk    (aclk),
        .ctrl    (lane_ctrl),
        .fg_chan (foreground_reg[23:16]),
        .bg_chan (br2_reg),
        .alpha   (alpha2_reg),
        .mixed   (mix_r)
    );

    gcab_mix_lane u_lane_g (
        .aclk    (aclk),
        .ctrl    (lane_ctrl),
        .fg_chan (foreground_reg[15:8]),
        .bg_chan (bgn2_reg),
        .alpha   (alpha2_reg),
        .mixed   (mix_g)
    );

    gcab_mix_lane u_lane_b (
        .aclk    (aclk),
        .ctrl    (lane_ctrl),
        .fg_chan (foreground_reg[7:0]),
        .bg_chan (bb2_reg),
        .alpha   (alpha2_reg),
        .mixed   (mix_b)
    );

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            alpha3_reg <= alpha2_reg;
            bgc3_reg   <= bgc2_reg;
        end
        if (stage_en[4]) begin
            alpha4_reg <= alpha3_reg;
            bgc4_reg   <= bgc3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: narrow the channels back to RGB565 where needed, pack, and
    // fall back to the untouched background when the opacity is zero.
    // This is the output register.
    // ------------------------------------------------------------------
    logic [13:0] nr5;
    logic [13:0] ng5;
    logic [13:0] nb5;
    logic [7:0]  qr5;
    logic [7:0]  qg5;
    logic [7:0]  qb5;
    logic [23:0] pixel5_next;

    logic        write_enable_reg;
    logic [23:0] new_pixel_reg;
    logic [7:0]  opacity_reg;

    always_comb begin
        nr5 = {1'b0, mix_r, 5'd0} - {6'd0, mix_r} + 14'd127;
        ng5 = {mix_g, 6'd0} - {6'd0, mix_g} + 14'd127;
        nb5 = {1'b0, mix_b, 5'd0} - {6'd0, mix_b} + 14'd127;
        qr5 = div255({2'b00, nr5});
        qg5 = div255({2'b00, ng5});
        qb5 = div255({2'b00, nb5});

        if (alpha4_reg == 8'd0) begin
            pixel5_next = bgc4_reg;
        end else if (pixel_format_reg == FORMAT_BGR888) begin
            pixel5_next = {mix_r, mix_g, mix_b};
        end else begin
            pixel5_next = {8'd0, qr5[4:0], qg5[5:0], qb5[4:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            write_enable_reg <= (alpha4_reg != 8'd0);
            new_pixel_reg    <= pixel5_next;
            opacity_reg      <= alpha4_reg;
        end
    end

    assign m_valid        = stage_valid_reg[5];
    assign m_write_enable = write_enable_reg;
    assign m_new_pixel    = new_pixel_reg;
    assign m_opacity      = opacity_reg;

    // ------------------------------------------------------------------
    // Checks on the pipeline control and the result fields.
    // ------------------------------------------------------------------
    `ASSERT_IMPLIES(a_stall_only_when_full, aclk, aresetn, !s_ready, &stage_valid_reg)
    `ASSERT_NEXT(a_accept_fills_first_stage, aclk, aresetn, s_valid && s_ready,
                 stage_valid_reg[0])
    `ASSERT_NEXT(a_held_stage_keeps_item, aclk, aresetn,
                 stage_valid_reg[2] && !stage_en[2], stage_valid_reg[2])
    `ASSERT_IMPLIES(a_write_matches_opacity, aclk, aresetn, m_valid,
                    m_write_enable == (m_opacity != 8'd0))

endmodule

`default_nettype wire

[design/gcab_mix_lane.sv]
`default_nettype none

module gcab_mix_lane (
    input  wire logic                      aclk,
    input  wire gcab_pkg::gcab_lane_ctrl_t ctrl,
    input  wire logic [7:0]                fg_chan,
    input  wire logic [7:0]                bg_chan,
    input  wire logic [7:0]                alpha,
    output logic [7:0]                     mixed
);
    import gcab_pkg::*;

    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic [7:0]  mixed_reg;

    // Weighted sum of foreground and background with the rounding term.
    always_comb begin
        sum_next = ({8'd0, fg_chan} * {8'd0, alpha})
                 + ({8'd0, bg_chan} * {8'd0, 8'd255 - alpha})
                 + 16'd127;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en_mix) begin
            sum_reg <= sum_next;
        end
        if (ctrl.en_div) begin
            mixed_reg <= div255(sum_reg);
        end
    end

    assign mixed = mixed_reg;

endmodule

`default_nettype wire

[bench/glyph_blend_checker.sv]
module glyph_blend_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_write_enable,
    input  logic [gcab_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gcab_pkg::CFG_DATA_W-1:0]     cfg_write_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [15:0]                         s_coverage_window,
    input  logic [2:0]                          s_bit_position,
    input  logic [23:0]                         s_background_pixel,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_write_enable,
    input  logic [23:0]                         m_new_pixel,
    input  logic [7:0]                          m_opacity,
    output int                                  mismatches,
    output int                                  pixels_in_flight,
    output int                                  pixels_checked,
    output int                                  pixels_written
);

    typedef struct packed {
        logic        write_enable;
        logic [23:0] new_pixel;
        logic [7:0]  opacity;
    } blended_pixel_t;

    blended_pixel_t blended_pixels[$];

    // Shadow copy of the block's registers, tracked from the write port.
    logic        pixel_format;
    logic [3:0]  cov_width;
    logic [23:0] text_colour;

    function automatic int unsigned scale_coverage(input logic [15:0] window,
                                                   input logic [2:0] pos,
                                                   input logic [3:0] width);
        int unsigned shift;
        int unsigned mask;
        int unsigned level;
        if (width == 4'd0 || width > 4'd8) begin
            return 0;
        end
        shift = 32'd16 - {29'd0, pos} - {28'd0, width};
        mask  = (32'd1 << width) - 32'd1;
        level = ({16'd0, window} >> shift) & mask;
        return (level * 255 + mask / 2) / mask;
    endfunction

    function automatic int unsigned mix_channel(input int unsigned fore,
                                                input int unsigned back,
                                                input int unsigned alpha);
        return (fore * alpha + back * (255 - alpha) + 127) / 255;
    endfunction

    function automatic blended_pixel_t predict_blend(input logic [15:0] window,
                                                     input logic [2:0] pos,
                                                     input logic [23:0] background);
        int unsigned alpha;
        int unsigned back_r, back_g, back_b;
        int unsigned red, green, blue;
        int unsigned passthrough, packed_px;
        blended_pixel_t result;
        alpha = scale_coverage(window, pos, cov_width);
        if (pixel_format == gcab_pkg::FORMAT_BGR888) begin
            passthrough = {8'd0, background};
            back_r = {24'd0, background[23:16]};
            back_g = {24'd0, background[15:8]};
            back_b = {24'd0, background[7:0]};
        end else begin
            passthrough = {16'd0, background[15:0]};
            back_r = {27'd0, background[15:11]};
            back_g = {26'd0, background[10:5]};
            back_b = {27'd0, background[4:0]};
            back_r = (back_r * 255 + 15) / 31;
            back_g = (back_g * 255 + 31) / 63;
            back_b = (back_b * 255 + 15) / 31;
        end
        red   = mix_channel({24'd0, text_colour[23:16]}, back_r, alpha);
        green = mix_channel({24'd0, text_colour[15:8]}, back_g, alpha);
        blue  = mix_channel({24'd0, text_colour[7:0]}, back_b, alpha);
        if (alpha == 0) begin
            packed_px = passthrough;
        end else if (pixel_format == gcab_pkg::FORMAT_BGR888) begin
            packed_px = (red << 16) | (green << 8) | blue;
        end else begin
            packed_px = (((red * 31 + 127) / 255) << 11)
                      | (((green * 63 + 127) / 255) << 5)
                      | ((blue * 31 + 127) / 255);
        end
        result.write_enable = (alpha != 0);
        result.new_pixel    = packed_px[23:0];
        result.opacity      = alpha[7:0];
        return result;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at pixel %0d: %s", pixels_checked, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        blended_pixel_t want;
        if (!aresetn) begin
            pixel_format = gcab_pkg::FORMAT_RGB565;
            cov_width    = 4'd8;
            text_colour  = 24'd0;
            blended_pixels.delete();
        end else begin
            if (cfg_write_enable) begin
                case (cfg_index)
                    gcab_pkg::CFG_PIXEL_FORMAT:  pixel_format = cfg_write_data[0];
                    gcab_pkg::CFG_COVERAGE_BITS: cov_width    = cfg_write_data[3:0];
                    gcab_pkg::CFG_FOREGROUND:    text_colour  = cfg_write_data[23:0];
                    default: ;
                endcase
            end
            // Results are matched before the new transfer is queued.
            if (m_valid && m_ready) begin
                if (blended_pixels.size() == 0) begin
                    report_mismatch("result with no pixel outstanding");
                end else begin
                    want = blended_pixels.pop_front();
                    if (m_write_enable !== want.write_enable) begin
                        report_mismatch($sformatf("write_enable got %0b, expected %0b",
                                                  m_write_enable, want.write_enable));
                    end
                    if (m_new_pixel !== want.new_pixel) begin
                        report_mismatch($sformatf("new_pixel got 0x%06h, expected 0x%06h",
                                                  m_new_pixel, want.new_pixel));
                    end
                    if (m_opacity !== want.opacity) begin
                        report_mismatch($sformatf("opacity got %0d, expected %0d",
                                                  m_opacity, want.opacity));
                    end
                    if (want.write_enable) begin
                        pixels_written++;
                    end
                end
                pixels_checked++;
            end
            if (s_valid && s_ready) begin
                blended_pixels.push_back(predict_blend(s_coverage_window, s_bit_position,
                                                       s_background_pixel));
            end
        end
        pixels_in_flight <= blended_pixels.size();
    end

endmodule

[bench/glyph_coverage_alpha_blend_tb.sv]
module glyph_coverage_alpha_blend_tb;

    import gcab_pkg::*;

    // A full pipeline under a long receiver hold-off sits with no transfer at all,
    // so the watchdog limit is set well above the length of that hold-off.
    localparam int LONG_HOLD       = 300;
    localparam int IDLE_LIMIT      = 3000;
    // The block has six stages; a few spare cycles are allowed after the last result.
    localparam int DRAIN_CYCLES    = 12;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int HOLD_ITEMS      = 60;

    // Index 3 is not decoded by the block; a write to it must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    // Patterns the receiver switches between on its own.
    typedef enum int {
        SINK_ALWAYS_READY,
        SINK_COIN_TOSS,
        SINK_MOSTLY_READY,
        SINK_MOSTLY_STALLED
    } sink_mode_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_write_enable;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_write_data;
    logic                   s_valid;
    logic                   s_ready;
    logic [15:0]            s_coverage_window;
    logic [2:0]             s_bit_position;
    logic [23:0]            s_background_pixel;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_write_enable;
    logic [23:0]            m_new_pixel;
    logic [7:0]             m_opacity;

    int mismatches;
    int pixels_in_flight;
    int pixels_checked;
    int pixels_written;

    // Toggled by the stimulus to ask the receiver for one long hold-off.
    logic hold_trigger;
    int   settings_used;

    always #5 aclk = ~aclk;

    glyph_coverage_alpha_blend dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_write_enable   (cfg_write_enable),
        .cfg_index          (cfg_index),
        .cfg_write_data     (cfg_write_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_coverage_window  (s_coverage_window),
        .s_bit_position     (s_bit_position),
        .s_background_pixel (s_background_pixel),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_write_enable     (m_write_enable),
        .m_new_pixel        (m_new_pixel),
        .m_opacity          (m_opacity)
    );

    // The checker sees both channels and the register port exactly as the block
    // does, predicts every result and hands back its failure count.
    glyph_blend_checker pixel_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_write_enable   (cfg_write_enable),
        .cfg_index          (cfg_index),
        .cfg_write_data     (cfg_write_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_coverage_window  (s_coverage_window),
        .s_bit_position     (s_bit_position),
        .s_background_pixel (s_background_pixel),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_write_enable     (m_write_enable),
        .m_new_pixel        (m_new_pixel),
        .m_opacity          (m_opacity),
        .mismatches         (mismatches),
        .pixels_in_flight   (pixels_in_flight),
        .pixels_checked     (pixels_checked),
        .pixels_written     (pixels_written)
    );

    // Every task below is entered just after a rising edge and returns just
    // after one, so all drives land as nonblocking updates at that edge.

    // Offers one pixel and waits for its transfer. Valid is raised without
    // looking at ready and held, with the payload, until the transfer happens.
    task automatic offer_pixel(input logic [15:0] window, input logic [2:0] pos,
                               input logic [23:0] background);
        s_valid            <= 1'b1;
        s_coverage_window  <= window;
        s_bit_position     <= pos;
        s_background_pixel <= background;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    // Drops valid for a number of cycles. A zero gap leaves valid high, so
    // back-to-back transfers never see valid lowered and raised in one step.
    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // Stops offering and waits until every predicted result has been seen.
    // The first edge lets the checker count the final input transfer.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pixels_in_flight != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes all three registers on consecutive edges, optionally followed by
    // a write to the undecoded index. The block must be idle when this runs.
    task automatic load_registers(input logic [23:0] format_word,
                                  input logic [23:0] width_word,
                                  input logic [23:0] colour_word,
                                  input logic poke_unused);
        cfg_write_enable <= 1'b1;
        cfg_index        <= CFG_PIXEL_FORMAT;
        cfg_write_data   <= format_word;
        @(posedge aclk);
        cfg_index        <= CFG_COVERAGE_BITS;
        cfg_write_data   <= width_word;
        @(posedge aclk);
        cfg_index        <= CFG_FOREGROUND;
        cfg_write_data   <= colour_word;
        @(posedge aclk);
        if (poke_unused) begin
            cfg_index      <= CFG_UNUSED_INDEX;
            cfg_write_data <= CFG_DATA_W'($urandom);
            @(posedge aclk);
        end
        cfg_write_enable <= 1'b0;
        settings_used++;
    endtask

    // Random pixels in bursts. With gaps enabled, two bursts in three are followed by an
    // idle stretch of random length; otherwise the sender never lets go.
    // An eighth of the windows are all clear and an eighth fully covered.
    task automatic stream_random(input int count, input logic with_gaps);
        int          left;
        int          burst;
        logic [15:0] window;
        logic [2:0]  pos;
        logic [23:0] background;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 30);
            if (burst > left) begin
                burst = left;
            end
            repeat (burst) begin
                case ($urandom_range(0, 7))
                    0:       window = 16'h0000;
                    1:       window = 16'hFFFF;
                    default: window = 16'($urandom);
                endcase
                case ($urandom_range(0, 15))
                    0:       background = 24'h000000;
                    1:       background = 24'hFFFFFF;
                    default: background = 24'($urandom);
                endcase
                pos = 3'($urandom_range(0, 7));
                offer_pixel(window, pos, background);
            end
            left -= burst;
            if (with_gaps && $urandom_range(0, 2) != 0) begin
                pause_sender($urandom_range(1, 8));
            end
        end
    endtask

    // Receiver: it keeps a randomly picked ready pattern for a random stretch, and
    // when the stimulus toggles hold_trigger it holds ready low through a long
    // hold-off, counted here, so that the pipeline fills and s_ready falls.
    initial begin
        sink_mode_t mode;
        int         mode_left;
        int         hold_left;
        logic       seen_trigger;
        mode         = SINK_ALWAYS_READY;
        mode_left    = 0;
        hold_left    = 0;
        seen_trigger = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_trigger !== seen_trigger) begin
                seen_trigger = hold_trigger;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = sink_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    SINK_ALWAYS_READY:   m_ready <= 1'b1;
                    SINK_COIN_TOSS:      m_ready <= 1'($urandom_range(0, 1));
                    SINK_MOSTLY_READY:   m_ready <= ($urandom_range(0, 7) != 0);
                    default:             m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog: it counts the cycles in a row with no transfer on either channel
    // and abandons the run when that count reaches the watchdog limit.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Watchdog: no transfer for %0d cycles, %0d results still due.",
                 IDLE_LIMIT, pixels_in_flight);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [23:0] format_word;
        logic [23:0] width_word;
        logic [23:0] colour_word;
        logic [3:0]  width;
        int          phase;

        // Every input is known from time zero, with reset asserted from the start.
        aresetn            <= 1'b0;
        cfg_write_enable   <= 1'b0;
        cfg_index          <= CFG_PIXEL_FORMAT;
        cfg_write_data     <= '0;
        s_valid            <= 1'b0;
        s_coverage_window  <= '0;
        s_bit_position     <= '0;
        s_background_pixel <= '0;
        hold_trigger       <= 1'b0;
        settings_used = 1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Settings after reset: RGB565, eight-bit coverage, black text.
        // An empty window leaves the pixel alone; a full one paints it black,
        // and the upper byte of an RGB565 background must be ignored.
        offer_pixel(16'h0000, 3'd0, 24'h000000);
        offer_pixel(16'hFFFF, 3'd0, 24'hFFFFFF);
        offer_pixel(16'h01FE, 3'd7, 24'h00F81F);
        offer_pixel(16'h8000, 3'd0, 24'h0007E0);
        offer_pixel(16'h00FF, 3'd7, 24'hA5FFFF);
        wait_for_drain();

        // One-bit coverage in BGR888 with white text: a set bit paints white,
        // a clear one passes the full 24-bit background through.
        load_registers({23'd0, FORMAT_BGR888}, 24'd1, 24'hFFFFFF, 1'b0);
        offer_pixel(16'h8000, 3'd0, 24'h123456);
        offer_pixel(16'h0100, 3'd7, 24'hABCDEF);
        offer_pixel(16'h7FFF, 3'd0, 24'hFFFFFF);
        offer_pixel(16'hFEFF, 3'd7, 24'h000000);
        wait_for_drain();

        // Coverage widths outside one to eight give zero opacity whatever
        // the window holds.
        load_registers({23'd0, FORMAT_RGB565}, 24'd0, 24'h123456, 1'b0);
        offer_pixel(16'hFFFF, 3'd3, 24'hFFFFFF);
        offer_pixel(16'hA5A5, 3'd0, 24'h00ABCD);
        wait_for_drain();
        load_registers({23'd0, FORMAT_RGB565}, 24'd9, 24'hFFFFFF, 1'b0);
        offer_pixel(16'hFFFF, 3'd0, 24'h00F800);
        wait_for_drain();
        load_registers({23'd0, FORMAT_BGR888}, 24'd15, 24'hFFFFFF, 1'b0);
        offer_pixel(16'hFFFF, 3'd7, 24'h807060);
        wait_for_drain();

        // Four-bit samples, including ones that straddle the two bytes.
        load_registers({23'd0, FORMAT_BGR888}, 24'd4, 24'h00FF80, 1'b0);
        offer_pixel(16'hF000, 3'd0, 24'h102030);
        offer_pixel(16'h0800, 3'd4, 24'hFF00FF);
        offer_pixel(16'h0380, 3'd6, 24'h7F7F7F);
        offer_pixel(16'h01E0, 3'd7, 24'h000000);
        wait_for_drain();

        // Seven-bit samples in RGB565 with white text.
        load_registers({23'd0, FORMAT_RGB565}, 24'd7, 24'hFFFFFF, 1'b0);
        offer_pixel(16'h7F00, 3'd1, 24'h000000);
        offer_pixel(16'h0000, 3'd1, 24'h00FFFF);
        offer_pixel(16'h4000, 3'd1, 24'h0F0F0F);
        wait_for_drain();

        // Random phases, each with its own settings and a full drain before
        // the next register write. The first two pin the register extremes.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0) begin
                format_word = {23'd0, FORMAT_RGB565};
                width_word  = 24'd1;
                colour_word = 24'h000000;
            end else if (phase == 1) begin
                format_word = {23'd0, FORMAT_BGR888};
                width_word  = 24'd8;
                colour_word = 24'hFFFFFF;
            end else begin
                // Bits above each register's width are noise that the block
                // must drop; a tenth of the phases use an unusable width.
                format_word    = 24'($urandom);
                format_word[0] = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 9) == 0) begin
                    width = 4'($urandom_range(9, 16));
                end else begin
                    width = 4'($urandom_range(1, 8));
                end
                width_word      = 24'($urandom);
                width_word[3:0] = width;
                case ($urandom_range(0, 5))
                    0:       colour_word = 24'h000000;
                    1:       colour_word = 24'hFFFFFF;
                    default: colour_word = 24'($urandom);
                endcase
            end
            load_registers(format_word, width_word, colour_word, phase == 2);

            if (phase == 3) begin
                // The receiver goes quiet while the sender keeps offering
                // back to back, so the pipeline fills and stalls the input.
                hold_trigger <= ~hold_trigger;
                stream_random(HOLD_ITEMS, 1'b0);
            end
            stream_random(ITEMS_PER_PHASE, (phase % 3) != 0);
            wait_for_drain();
        end

        $display("Checked %0d blended pixels, %0d written and %0d left untouched.",
                 pixels_checked, pixels_written, pixels_checked - pixels_written);
        $display("Used %0d register settings in both formats, with a %0d-cycle %s",
                 settings_used, LONG_HOLD, "output hold-off.");
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
